// ===== hdl/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the chained hash set: command and result
// words, status codes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

  localparam int KEY_W       = 32;
  localparam int BUCKETS_DEF = 11;
  localparam int POOL_DEF    = 256;
  localparam int MOD_DIG     = 4;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] bucket;
  } res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_LOOKUP,
    S_DISPATCH,
    S_WALK_INS,
    S_WALK,
    S_DEL_FREE
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/chs_ram.sv =====
// ----------------------------------------------------------------------------
// chs_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/chs_mod.sv =====
// ----------------------------------------------------------------------------
// chs_mod
// Key remainder unit: key mod BUCKETS by restoring reduction, a few key
// bits per cycle, with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_mod #(
  parameter int  BUCKETS = chs_pkg::BUCKETS_DEF,
  localparam int BW      = $clog2(BUCKETS)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [chs_pkg::KEY_W-1:0]  key_i,
  output logic                            done_o,
  output logic      [BW-1:0]              rem_o
);

  import chs_pkg::*;

  localparam int STEPS = KEY_W / MOD_DIG;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int RW    = BW + 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [KEY_W-1:0] shf_q, shf_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [RW-1:0]    rem_step;

  // MOD_DIG compare-subtract steps per cycle
  always_comb begin
    rem_step = rem_q;
    for (int i = 0; i < MOD_DIG; i++) begin
      rem_step = {rem_step[RW-2:0], shf_q[KEY_W-1-i]};
      if (rem_step >= RW'(BUCKETS)) begin
        rem_step = rem_step - RW'(BUCKETS);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(STEPS - 1);
      shf_d  = key_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = rem_step;
      shf_d = shf_q << MOD_DIG;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[BW-1:0];

endmodule

`default_nettype wire

// ===== hdl/chained_hash_set.sv =====
// ----------------------------------------------------------------------------
// chained_hash_set
// Set of 32-bit keys in a hash table with separate chaining over a bounded
// node pool: insert (tail append, duplicates kept), delete and search.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the bucket head memory,
// with busy high, and takes no command until it ends. A command is taken
// when start is high and busy is low. The remainder unit then reduces the key
// four bits per cycle and hands the bucket over, the bucket head and free
// node are looked up, and the walk reads one node per cycle through the
// single read port of the node memory; for a successful delete an extra
// state, S_DEL_FREE, returns the node to the free list. Busy drops with the
// strobe, so the next command can be taken at the edge that ends it. Each
// result is shown for exactly one cycle with res_valid_o high and cannot be
// held off, so the receiver must take it then.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_set #(
  parameter int BUCKETS   = chs_pkg::BUCKETS_DEF,
  parameter int POOL_SIZE = chs_pkg::POOL_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire chs_pkg::req_t req_i,
  output logic               res_valid_o,
  output chs_pkg::res_t      res_o
);

  import chs_pkg::*;

  localparam int BW     = $clog2(BUCKETS);
  localparam int NW     = $clog2(POOL_SIZE + 1);
  localparam int PAW    = $clog2(POOL_SIZE);
  localparam int NODE_W = KEY_W + NW;
  localparam logic [NW-1:0] NIL = NW'(POOL_SIZE);

  state_e           state_q, state_d;
  logic [BW-1:0]    clr_q, clr_d;
  logic [NW-1:0]    free_q, free_d;
  logic [NW-1:0]    fresh_q, fresh_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;
  cmd_e             cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [BW-1:0]    bucket_q, bucket_d;
  logic [NW-1:0]    n_q, n_d;
  logic [NW-1:0]    cur_q, cur_d;
  logic [NW-1:0]    prev_q, prev_d;
  logic [KEY_W-1:0] prev_key_q, prev_key_d;

  logic             head_we;
  logic [BW-1:0]    head_waddr;
  logic [NW-1:0]    head_wdata;
  logic [NW-1:0]    head_rdata;
  logic             node_we;
  logic [PAW-1:0]   node_waddr;
  logic [NODE_W-1:0] node_wdata;
  logic [NODE_W-1:0] node_rdata;
  logic [NW-1:0]    node_rd;
  logic [KEY_W-1:0] node_rkey;
  logic [NW-1:0]    node_rlink;

  logic             mod_start;
  logic             mod_done;
  logic [BW-1:0]    mod_rem;
  logic [BW+3:0]    bucket_ext;

  assign mod_start  = start && (state_q == S_IDLE);
  assign node_rkey  = node_rdata[NODE_W-1:NW];
  assign node_rlink = node_rdata[NW-1:0];
  assign bucket_ext = {4'b0000, bucket_q};

  chs_mod #(
    .BUCKETS (BUCKETS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (req_i.key),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  chs_ram #(
    .WIDTH (NW),
    .DEPTH (BUCKETS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (bucket_q),
    .rdata_o (head_rdata)
  );

  chs_ram #(
    .WIDTH (NODE_W),
    .DEPTH (POOL_SIZE)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_rd[PAW-1:0]),
    .rdata_o (node_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    free_d      = free_q;
    fresh_d     = fresh_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    res_d.bucket = bucket_ext[3:0];
    cmd_d       = cmd_q;
    key_d       = key_q;
    bucket_d    = bucket_q;
    n_d         = n_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    prev_key_d  = prev_key_q;
    head_we     = 1'b0;
    head_waddr  = bucket_q;
    head_wdata  = NIL;
    node_we     = 1'b0;
    node_waddr  = cur_q[PAW-1:0];
    node_wdata  = {key_q, NIL};
    node_rd     = free_q;

    unique case (state_q)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = NIL;
        clr_d      = clr_q + 1'b1;
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_d   = req_i.cmd;
          key_d   = req_i.key;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          bucket_d = mod_rem;
          state_d  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        node_rd = free_q;
        state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (cmd_q) inside
          CMD_INSERT: begin
            if ((free_q == NIL) && (fresh_q == NIL)) begin
              res_valid_d  = 1'b1;
              res_d.status = ST_FULL;
              state_d      = S_IDLE;
            end else begin
              if (free_q != NIL) begin
                n_d    = free_q;
                free_d = node_rlink;
              end else begin
                n_d     = fresh_q;
                fresh_d = fresh_q + 1'b1;
              end
              node_we    = 1'b1;
              node_waddr = n_d[PAW-1:0];
              node_wdata = {key_q, NIL};
              if (head_rdata == NIL) begin
                head_we      = 1'b1;
                head_wdata   = n_d;
                res_valid_d  = 1'b1;
                res_d.status = ST_DONE;
                state_d      = S_IDLE;
              end else begin
                cur_d   = head_rdata;
                node_rd = head_rdata;
                state_d = S_WALK_INS;
              end
            end
          end
          CMD_DELETE, CMD_SEARCH: begin
            if (head_rdata == NIL) begin
              res_valid_d  = 1'b1;
              res_d.status = ST_MISS;
              state_d      = S_IDLE;
            end else begin
              cur_d   = head_rdata;
              prev_d  = NIL;
              node_rd = head_rdata;
              state_d = S_WALK;
            end
          end
          default: begin
            res_valid_d  = 1'b1;
            res_d.status = ST_MISS;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_WALK_INS: begin
        if (node_rlink != NIL) begin
          cur_d   = node_rlink;
          node_rd = node_rlink;
        end else begin
          node_we      = 1'b1;
          node_waddr   = cur_q[PAW-1:0];
          node_wdata   = {node_rkey, n_q};
          res_valid_d  = 1'b1;
          res_d.status = ST_DONE;
          state_d      = S_IDLE;
        end
      end
      S_WALK: begin
        if (node_rkey == key_q) begin
          if (cmd_q == CMD_DELETE) begin
            // unlink: predecessor or bucket head takes the successor
            if (prev_q != NIL) begin
              node_we    = 1'b1;
              node_waddr = prev_q[PAW-1:0];
              node_wdata = {prev_key_q, node_rlink};
            end else begin
              head_we    = 1'b1;
              head_wdata = node_rlink;
            end
            state_d = S_DEL_FREE;
          end else begin
            res_valid_d  = 1'b1;
            res_d.status = ST_DONE;
            state_d      = S_IDLE;
          end
        end else if (node_rlink == NIL) begin
          res_valid_d  = 1'b1;
          res_d.status = ST_MISS;
          state_d      = S_IDLE;
        end else begin
          prev_d     = cur_q;
          prev_key_d = node_rkey;
          cur_d      = node_rlink;
          node_rd    = node_rlink;
        end
      end
      S_DEL_FREE: begin
        // push the freed node on the free list
        node_we      = 1'b1;
        node_waddr   = cur_q[PAW-1:0];
        node_wdata   = {key_q, free_q};
        free_d       = cur_q;
        res_valid_d  = 1'b1;
        res_d.status = ST_DONE;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      free_q      <= NIL;
      fresh_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_q      <= free_d;
      fresh_q     <= fresh_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    bucket_q   <= bucket_d;
    n_q        <= n_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    prev_key_q <= prev_key_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hdl/chs_checker.sv =====
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the command handshake and result strobe, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          res_valid_o,
  input wire chs_pkg::res_t res_o
);

  import chs_pkg::*;

  // an accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // no result in the cycle right after acceptance
  a_no_early_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !res_valid_o)
    else $error("result strobe right after accept");

  // a result strobe lasts one cycle
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  // a result closes a busy period
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe outside end of command");

  // every result carries a valid status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.status == ST_DONE || res_o.status == ST_MISS ||
                     res_o.status == ST_FULL))
    else $error("bad status code");

endmodule

bind chained_hash_set chs_checker u_chs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

`default_nettype wire

// ===== tb/sv/tb_chained_hash_set.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chained_hash_set
// Self-checking bench for the chained hash set. A key-count model predicts
// status and bucket for every accepted command word, and each result word is
// checked against it in order. The bench runs a short directed set, then
// fills the node pool to overflow through one long chain and drains it, then
// runs random traffic with random gaps on the command side.
// ----------------------------------------------------------------------------

module tb_chained_hash_set;
  import chs_pkg::*;

  localparam int unsigned N_BUCKETS    = BUCKETS_DEF;
  localparam int unsigned POOL_NODES   = POOL_DEF;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  chained_hash_set #(
    .BUCKETS  (N_BUCKETS),
    .POOL_SIZE(POOL_NODES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // model of the set: copies of each key held, and nodes taken from the pool
  int unsigned key_copies [logic [31:0]];
  int unsigned nodes_used = 0;
  logic [31:0] seen_keys [$];
  res_t        answers_due [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          no_gaps = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic res_t hash_set_answer(input req_t w);
    res_t        a;
    logic [31:0] k;
    k = w.key;
    a.bucket = 4'(k % N_BUCKETS);
    a.status = ST_MISS;
    case (w.cmd)
      CMD_INSERT: begin
        if (nodes_used == POOL_NODES) begin
          a.status = ST_FULL;
        end else begin
          nodes_used++;
          if (key_copies.exists(k)) key_copies[k]++;
          else key_copies[k] = 1;
          a.status = ST_DONE;
        end
      end
      CMD_DELETE: begin
        if (key_copies.exists(k)) begin
          if (key_copies[k] == 1) key_copies.delete(k);
          else key_copies[k]--;
          nodes_used--;
          a.status = ST_DONE;
        end
      end
      CMD_SEARCH: begin
        if (key_copies.exists(k)) a.status = ST_DONE;
      end
      default: a.status = ST_MISS;
    endcase
    return a;
  endfunction

  function automatic req_t word_of(input cmd_e c, input logic [31:0] k);
    req_t w;
    w.cmd = c;
    w.key = k;
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input req_t w);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      req_i <= '{cmd: cmd_e'(2'($urandom)), key: $urandom};
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    answers_due.push_back(hash_set_answer(w));
  endtask

  task automatic test_directed();
    send_word(word_of(CMD_SEARCH, 32'h0));
    send_word(word_of(CMD_INSERT, 32'h0));
    send_word(word_of(CMD_INSERT, 32'hFFFF_FFFF));
    send_word(word_of(CMD_SEARCH, 32'h0));
    send_word(word_of(CMD_SEARCH, 32'hFFFF_FFFF));
    send_word(word_of(CMD_INSERT, 32'h0));
    send_word(word_of(CMD_DELETE, 32'h0));
    send_word(word_of(CMD_SEARCH, 32'h0));
    send_word(word_of(CMD_DELETE, 32'h0));
    send_word(word_of(CMD_SEARCH, 32'h0));
    send_word(word_of(CMD_DELETE, 32'h0));
    send_word(word_of(CMD_INSERT, 32'd11));
    send_word(word_of(CMD_INSERT, 32'd22));
    send_word(word_of(CMD_INSERT, 32'd33));
    send_word(word_of(CMD_DELETE, 32'd22));
    send_word(word_of(CMD_SEARCH, 32'd33));
    send_word(word_of(CMD_SEARCH, 32'd22));
    send_word(word_of(CMD_INSERT, 32'd44));
    send_word(word_of(CMD_SEARCH, 32'd44));
    send_word(word_of(cmd_e'(CMD_UNUSED), 32'hFFFF_FFFF));
    send_word(word_of(cmd_e'(CMD_UNUSED), 32'h0));
    send_word(word_of(CMD_INSERT, 32'hAAAA_AAAA));
    send_word(word_of(CMD_SEARCH, 32'h5555_5555));
    send_word(word_of(CMD_INSERT, 32'h5555_5555));
    send_word(word_of(CMD_DELETE, 32'hAAAA_AAAA));
  endtask

  // one long chain up to pool overflow, free-list reuse, then drain from the tail
  task automatic test_pool_exhaustion();
    logic [31:0] fill_keys [$];
    logic [31:0] k;
    while (nodes_used < POOL_NODES) begin
      k = $urandom_range(0, 32'h1745_D172) * 11 + 7;
      fill_keys.push_back(k);
      send_word(word_of(CMD_INSERT, k));
    end
    repeat (3) send_word(word_of(CMD_INSERT, $urandom));
    send_word(word_of(CMD_SEARCH, fill_keys[$]));
    send_word(word_of(CMD_SEARCH, 32'd7));
    send_word(word_of(CMD_DELETE, fill_keys[0]));
    void'(fill_keys.pop_front());
    k = 32'd18;
    fill_keys.push_back(k);
    send_word(word_of(CMD_INSERT, k));
    send_word(word_of(CMD_INSERT, 32'd29));
    send_word(word_of(CMD_SEARCH, k));
    while (fill_keys.size() != 0) send_word(word_of(CMD_DELETE, fill_keys.pop_back()));
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned r;
    bit          growing;
    cmd_e        c;
    logic [31:0] k;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(3) == 0);
      growing = ((i / 250) % 2) == 0;
      r = $urandom_range(99);
      if (r < 5) c = cmd_e'(CMD_UNUSED);
      else if (r < (growing ? 60 : 25)) c = CMD_INSERT;
      else if (r < (growing ? 75 : 70)) c = CMD_DELETE;
      else c = CMD_SEARCH;
      r = $urandom_range(99);
      if (r < 45 && seen_keys.size() != 0) k = seen_keys[$urandom_range(seen_keys.size() - 1)];
      else if (r < 60) k = $urandom_range(0, 40);
      else if (r < 75) k = $urandom_range(0, 1000) * 11 + 3;
      else k = $urandom;
      if (c == CMD_INSERT) begin
        seen_keys.push_back(k);
        if (seen_keys.size() > 300) void'(seen_keys.pop_front());
      end
      send_word(word_of(c, k));
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) begin
    res_t due;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (answers_due.size() == 0) begin
        report_mismatch("result word with nothing due", 32'(res_o), 32'h0);
      end else begin
        due = answers_due.pop_front();
        if (res_o.status !== due.status) report_mismatch("status", res_o.status, due.status);
        if (res_o.bucket !== due.bucket) report_mismatch("bucket", res_o.bucket, due.bucket);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || res_valid_o === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("tb_chained_hash_set NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_pool_exhaustion();
    test_random(1000);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_chained_hash_set OK");
    end else begin
      $display("tb_chained_hash_set NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/chs_pkg.sv
hdl/chs_ram.sv
hdl/chs_mod.sv
hdl/chained_hash_set.sv
hdl/chs_checker.sv
tb/sv/tb_chained_hash_set.sv
